>>> hdl/fsrl_pkg.sv
`timescale 1ns / 1ps

package fsrl_pkg;

	// Sector geometry: SLOTS slots of four bytes, slot 0 is the header
	localparam int SLOTS        = 32;
	localparam int FULL_AT_INIT = 30;
	localparam int SLOT_W       = $clog2(SLOTS);
	// next_slot never exceeds FULL_AT_INIT + 1
	localparam int NS_W         = $clog2(FULL_AT_INIT + 2);
	localparam int CMP_W        = ((NS_W > SLOT_W) ? NS_W : SLOT_W) + 2;
	localparam int ROW_W        = 32;

	localparam logic [7:0]       REC_MARK   = 8'hA5;
	localparam logic [7:0]       HDR_MARK   = 8'h5A;
	localparam logic [ROW_W-1:0] ERASED_ROW = '1;

	// Settings emitted on power recovery in test mode
	localparam logic [7:0] RST_SPEED = 8'd1;
	localparam logic [7:0] RST_HEAT  = 8'd1;
	localparam logic [7:0] RST_COOL  = 8'd0;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_TEST_MODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_SPEED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_HEAT  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_COOL  = 2'd3;

	// Operation codes
	localparam logic OP_RESTORE = 1'b0;
	localparam logic OP_TICK    = 1'b1;

	// Save phase codes
	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_PENDING = 2'd1;
	localparam logic [1:0] PH_SAVED   = 2'd2;

	// One returned sector row for the scan unit
	typedef struct packed {
		logic              act;
		logic [SLOT_W-1:0] idx;
		logic [ROW_W-1:0]  row;
	} scan_ctl_t;

	// What the scan has found so far
	typedef struct packed {
		logic              hdr_ok;
		logic [15:0]       hdr_cnt;
		logic [SLOT_W-1:0] found;
		logic [7:0]        speed;
		logic [7:0]        heat;
		logic [7:0]        cool;
	} scan_res_t;

endpackage

>>> hdl/fsrl_ram.sv
`timescale 1ns / 1ps

module fsrl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hdl/fsrl_scan.sv
`timescale 1ns / 1ps

module fsrl_scan import fsrl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  scan_ctl_t ctl,
	output scan_res_t res
);

	logic hdr_ok_q;
	logic [15:0] hdr_cnt_q;
	logic [SLOT_W-1:0] found_q;
	logic [7:0] speed_q, heat_q, cool_q;
	logic mark_hit;

	// Shared marker compare, used for the header and for every record slot
	assign mark_hit = (ctl.row[7:0] == REC_MARK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_ok_q <= 1'b0;
		end else if (ctl.act && (ctl.idx == '0)) begin
			hdr_ok_q <= mark_hit;
		end
	end

	// Header count and newest record; slot 1 is taken as fallback
	always_ff @(posedge clk) begin
		if (ctl.act) begin
			if (ctl.idx == '0) begin
				hdr_cnt_q <= ctl.row[31:16];
			end else if (mark_hit || (ctl.idx == SLOT_W'(1))) begin
				found_q <= ctl.idx;
				speed_q <= ctl.row[15:8];
				heat_q  <= ctl.row[23:16];
				cool_q  <= ctl.row[31:24];
			end
		end
	end

	assign res.hdr_ok  = hdr_ok_q;
	assign res.hdr_cnt = hdr_cnt_q;
	assign res.found   = found_q;
	assign res.speed   = speed_q;
	assign res.heat    = heat_q;
	assign res.cool    = cool_q;

endmodule

>>> hdl/flash_settings_record_log.sv
`timescale 1ns / 1ps

// Settings record log on an emulated 128-byte flash sector (32 slots of 4 bytes).
// Pulse start while busy is low to hand over one item; exactly one result follows,
// shown for a single cycle while done is high, and it must be taken then since
// the block cannot be stalled. A power-up restore scans the sector one slot per
// cycle through the single read port of the sector memory and may then erase
// and rewrite the sector. A tick may append a record, or erase and rewrite the
// sector, the header and the first record going through the single write port
// one after the other. Erasing clears the valid flags of all slots but the
// header's at once; reset leaves the sector erased with no clearing pass.
// Configuration writes (wr_en, wr_index, wr_data) take effect at once and
// belong in idle time only.
module flash_settings_record_log import fsrl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 operation,
	input  logic                 power_lost,
	input  logic                 motor_ready,
	input  logic [7:0]           speed_step,
	input  logic [7:0]           heat_step,
	input  logic [7:0]           cool_level,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [7:0]           wr_data,
	output logic                 done,
	output logic                 settings_update,
	output logic [7:0]           new_speed,
	output logic [7:0]           new_heat,
	output logic [7:0]           new_cool,
	output logic                 record_saved,
	output logic                 sector_erased,
	output logic [15:0]          erase_total,
	output logic [4:0]           next_record
);

	typedef enum logic [7:0] {
		ST_IDLE      = 8'b0000_0001,
		ST_DECIDE    = 8'b0000_0010,
		ST_SCAN      = 8'b0000_0100,
		ST_SCAN_WAIT = 8'b0000_1000,
		ST_EVAL      = 8'b0001_0000,
		ST_ERASE     = 8'b0010_0000,
		ST_WRITE     = 8'b0100_0000,
		ST_DONE      = 8'b1000_0000
	} state_t;

	state_t state_q;

	// Configuration
	logic       test_mode_q;
	logic [7:0] def_speed_q, def_heat_q, def_cool_q;

	// Persistent state
	logic [NS_W-1:0]  next_slot_q;
	logic [15:0]      erase_count_q;
	logic [1:0]       phase_q;
	logic             init_done_q;
	logic [SLOTS-1:0] valid_q;

	// Latched item
	logic       op_q, lost_q, ready_q;
	logic [7:0] in_speed_q, in_heat_q, in_cool_q;

	// Working registers
	logic [SLOT_W-1:0] scan_idx_q;
	logic [SLOT_W-1:0] wr_slot_q;
	logic [7:0]        rec_speed_q, rec_heat_q, rec_cool_q;
	logic              res_upd_q, res_saved_q, res_erased_q;
	logic [7:0]        res_speed_q, res_heat_q, res_cool_q;

	// Read pipeline
	logic              rd_act_s1, rd_valid_s1;
	logic [SLOT_W-1:0] rd_idx_s1;

	// Memory port
	logic              ram_we;
	logic [SLOT_W-1:0] ram_waddr;
	logic [ROW_W-1:0]  ram_wdata;
	logic [ROW_W-1:0]  ram_rdata;

	scan_ctl_t scan_ctl;
	scan_res_t scan_res;

	// Shared erase counter incrementer
	logic [15:0] inc_in, inc_out;

	// Tick phase evaluation
	logic [1:0] ph_a, ph_b, ph_final;
	logic       do_save, ph_clear, ns_full, ns_in_sector, found_full;

	assign busy = (state_q != ST_IDLE);

	fsrl_ram #(
		.WIDTH(ROW_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (scan_idx_q),
		.rdata (ram_rdata)
	);

	// Rows never written since the last erase read as erased
	assign scan_ctl.act = rd_act_s1;
	assign scan_ctl.idx = rd_idx_s1;
	assign scan_ctl.row = rd_valid_s1 ? ram_rdata : ERASED_ROW;

	fsrl_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.res    (scan_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_act_s1 <= 1'b0;
		end else begin
			rd_act_s1 <= (state_q == ST_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1   <= scan_idx_q;
		rd_valid_s1 <= valid_q[scan_idx_q];
	end

	// Write port: header row during erase, record row otherwise
	always_comb begin
		ram_we    = (state_q == ST_ERASE) || (state_q == ST_WRITE);
		ram_waddr = wr_slot_q;
		ram_wdata = {rec_cool_q, rec_heat_q, rec_speed_q, REC_MARK};
		if (state_q == ST_ERASE) begin
			ram_waddr = '0;
			ram_wdata = {erase_count_q[15:8], erase_count_q[7:0], HDR_MARK, REC_MARK};
		end
	end

	assign inc_in  = (state_q == ST_EVAL) ? scan_res.hdr_cnt : erase_count_q;
	assign inc_out = inc_in + 16'd1;

	// Tick phase sequence
	always_comb begin
		ph_a     = (lost_q && ready_q && (phase_q == PH_IDLE)) ? PH_PENDING : phase_q;
		do_save  = (ph_a == PH_PENDING);
		ph_b     = do_save ? PH_SAVED : ph_a;
		ph_clear = (ph_b == PH_SAVED) && !lost_q;
		ph_final = ph_clear ? PH_IDLE : ph_b;
	end

	assign ns_full      = (next_slot_q > NS_W'(FULL_AT_INIT));
	assign ns_in_sector = (CMP_W'(next_slot_q) < CMP_W'(SLOTS));
	assign found_full   = (CMP_W'(scan_res.found) >= CMP_W'(FULL_AT_INIT));

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			test_mode_q <= 1'b0;
			def_speed_q <= 8'd1;
			def_heat_q  <= 8'd1;
			def_cool_q  <= 8'd0;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_TEST_MODE:     test_mode_q <= wr_data[0];
				CFG_DEFAULT_SPEED: def_speed_q <= wr_data;
				CFG_DEFAULT_HEAT:  def_heat_q  <= wr_data;
				CFG_DEFAULT_COOL:  def_cool_q  <= wr_data;
				default:           test_mode_q <= test_mode_q;
			endcase
		end
	end

	// Sequencer and persistent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			next_slot_q   <= '0;
			erase_count_q <= '0;
			phase_q       <= PH_IDLE;
			init_done_q   <= 1'b0;
			valid_q       <= '0;
			scan_idx_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (op_q == OP_RESTORE) begin
						if (init_done_q) begin
							state_q <= ST_DONE;
						end else begin
							init_done_q <= 1'b1;
							scan_idx_q  <= '0;
							state_q     <= ST_SCAN;
						end
					end else begin
						phase_q <= ph_final;
						if (do_save && !test_mode_q && ns_full) begin
							erase_count_q <= inc_out;
							state_q       <= ST_ERASE;
						end else if (do_save && !test_mode_q) begin
							next_slot_q <= next_slot_q + NS_W'(1);
							state_q     <= ns_in_sector ? ST_WRITE : ST_DONE;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					scan_idx_q <= scan_idx_q + SLOT_W'(1);
					if (scan_idx_q == SLOT_W'(SLOTS - 1)) begin
						state_q <= ST_SCAN_WAIT;
					end
				end
				ST_SCAN_WAIT: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (!scan_res.hdr_ok) begin
						erase_count_q <= 16'd1;
						state_q       <= ST_ERASE;
					end else if (found_full) begin
						erase_count_q <= inc_out;
						state_q       <= ST_ERASE;
					end else begin
						erase_count_q <= scan_res.hdr_cnt;
						next_slot_q   <= NS_W'(scan_res.found) + NS_W'(1);
						state_q       <= ST_DONE;
					end
				end
				ST_ERASE: begin
					valid_q     <= SLOTS'(1);
					next_slot_q <= NS_W'(2);
					state_q     <= ST_WRITE;
				end
				ST_WRITE: begin
					valid_q[wr_slot_q] <= 1'b1;
					state_q            <= ST_DONE;
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item latch, record data and result fields
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q         <= operation;
				lost_q       <= power_lost;
				ready_q      <= motor_ready;
				in_speed_q   <= speed_step;
				in_heat_q    <= heat_step;
				in_cool_q    <= cool_level;
				res_upd_q    <= 1'b0;
				res_saved_q  <= 1'b0;
				res_erased_q <= 1'b0;
				res_speed_q  <= '0;
				res_heat_q   <= '0;
				res_cool_q   <= '0;
			end
			ST_DECIDE: begin
				rec_speed_q <= in_speed_q;
				rec_heat_q  <= in_heat_q;
				rec_cool_q  <= in_cool_q;
				wr_slot_q   <= SLOT_W'(next_slot_q);
				if (op_q == OP_TICK) begin
					if (do_save && !test_mode_q) begin
						res_saved_q  <= ns_full || ns_in_sector;
						res_erased_q <= ns_full;
					end
					if (ph_clear && test_mode_q) begin
						res_upd_q   <= 1'b1;
						res_speed_q <= RST_SPEED;
						res_heat_q  <= RST_HEAT;
						res_cool_q  <= RST_COOL;
					end
				end
			end
			ST_EVAL: begin
				res_upd_q <= 1'b1;
				if (!scan_res.hdr_ok) begin
					rec_speed_q  <= def_speed_q;
					rec_heat_q   <= def_heat_q;
					rec_cool_q   <= def_cool_q;
					res_speed_q  <= def_speed_q;
					res_heat_q   <= def_heat_q;
					res_cool_q   <= def_cool_q;
					res_saved_q  <= 1'b1;
					res_erased_q <= 1'b1;
				end else begin
					rec_speed_q  <= scan_res.speed;
					rec_heat_q   <= scan_res.heat;
					rec_cool_q   <= scan_res.cool;
					res_speed_q  <= scan_res.speed;
					res_heat_q   <= scan_res.heat;
					res_cool_q   <= scan_res.cool;
					res_saved_q  <= found_full;
					res_erased_q <= found_full;
				end
			end
			ST_ERASE: begin
				wr_slot_q <= SLOT_W'(1);
			end
			default: begin
				wr_slot_q <= wr_slot_q;
			end
		endcase
	end

	// Result ports
	assign done            = (state_q == ST_DONE);
	assign settings_update = res_upd_q;
	assign new_speed       = res_speed_q;
	assign new_heat        = res_heat_q;
	assign new_cool        = res_cool_q;
	assign record_saved    = res_saved_q;
	assign sector_erased   = res_erased_q;
	assign erase_total     = erase_count_q;
	assign next_record     = 5'(next_slot_q);

	// An erase always rewrites the first record and leaves slot 2 next
	a_erase_saves: assert property (@(posedge clk) disable iff (!arst_n)
		done && sector_erased |-> record_saved && (next_record == 5'd2))
		else $error("erase without rewrite");

	// Memory is only written inside an item
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> busy && !done)
		else $error("sector write outside an item");

	// The result strobe lasts one cycle and frees the block
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("result strobe held");

	// An erase leaves only the header valid and moves on to the record write
	a_hdr_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ERASE) |=> (valid_q == SLOTS'(1)) && (state_q == ST_WRITE))
		else $error("erase sequence broken");

	// A restore only ever runs its scan once
	a_scan_once: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rd_act_s1) |-> init_done_q && $past(init_done_q) && (rd_idx_s1 == '0))
		else $error("scan started out of order");

endmodule
